// ===== design/sawts_pkg.sv =====
`timescale 1ns / 1ps
package sawts_pkg;

    localparam int ID_W       = 32;
    localparam int REC_W      = 32;
    localparam int PKT_W      = 16;
    localparam int SETS_W     = 8;
    localparam int SENS_W     = 6;
    localparam int CMD_W      = 2;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 8;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 8;
    localparam int MUL_P_W    = 32;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_SENSOR_COUNT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETS_PER_PACKET = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_SEED         = 2'd2;

    localparam logic [PKT_W-1:0] PKT_TOTAL_MAX = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_NACK    = 2'd2,
        CMD_BAD     = 2'd3
    } t_cmd;

endpackage

// ===== design/sawts_div.sv =====
`timescale 1ns / 1ps
module sawts_div
    import sawts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DIVIDEND_W);
                r_quo <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
                r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/sawts_mul.sv =====
`timescale 1ns / 1ps
module sawts_mul
    import sawts_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_A_W+MUL_B_W-1:0] full;
    logic [MUL_P_W-1:0]         r_p;

    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= full[MUL_P_W-1:0];
    end

    assign o_p = r_p;

endmodule

// ===== design/stop_and_wait_transfer_sender_core.sv =====
`timescale 1ns / 1ps
// Request: result set by two 32-step passes through the shared bit-serial divider
//   (pending sets, then packet count).
// Ack or nack: result set by three steps on the shared multiplier.
// Malformed or rejected message: empty result.
// One word in flight; the next word is taken once the result is in the output register.
// Reset is synchronous, active low; session cleared, sensor_count and sets_per_packet 1.
module stop_and_wait_transfer_sender_core
    import sawts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // payload_ok, nack_nonempty, msg_transfer_id, msg_seq, ring_oldest, ring_next,
    // ring_confirmed, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]      s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // reply_transfer_id, packet_seq, packet_total, packet_sets, first_record_seq,
    // sensors_per_set, confirm_seq, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // reply_valid, confirm_valid
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // end_flag
    output logic                  m_axis_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLAMP,
        ST_DIV_SETS,
        ST_WAIT_SETS,
        ST_DIV_PKTS,
        ST_WAIT_PKTS,
        ST_COMMIT,
        ST_MUL_OFF,
        ST_MUL_REC,
        ST_MUL_CONF,
        ST_DESC,
        ST_FINISH
    } t_state;

    t_state r_state;

    logic [SENS_W-1:0]  r_cfg_sensors;
    logic [SETS_W-1:0]  r_cfg_spp;
    logic [ID_W-1:0]    r_cfg_seed;

    t_cmd               r_cmd;
    logic               r_ok;
    logic               r_nonempty;
    logic [ID_W-1:0]    r_msg_id;
    logic [PKT_W-1:0]   r_msg_seq;
    logic [REC_W-1:0]   r_oldest;
    logic [REC_W-1:0]   r_next;
    logic [REC_W-1:0]   r_confirmed;
    logic [REC_W-1:0]   r_start;

    logic               r_session;
    logic [ID_W-1:0]    r_current_id;
    logic [ID_W-1:0]    r_id_counter;
    logic               r_id_seeded;
    logic [REC_W-1:0]   r_start_record;
    logic [REC_W-1:0]   r_total_sets;
    logic [SENS_W-1:0]  r_sens_snap;
    logic [SETS_W-1:0]  r_sets_snap;
    logic [PKT_W-1:0]   r_total_packets;
    logic [PKT_W-1:0]   r_last_sent;

    logic               r_reply;
    logic               r_conf;
    logic [PKT_W-1:0]   r_pkt;
    logic [SETS_W-1:0]  r_count;
    logic [REC_W-1:0]   r_first;
    logic [REC_W-1:0]   r_conf_seq;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_USER_W-1:0] r_m_user;
    logic                  r_m_last;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_q;
    logic [DIVISOR_W-1:0]  div_r;

    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]    mul_p;

    logic [SENS_W-1:0]     n_eff;
    logic [SETS_W-1:0]     spp_eff;
    logic [REC_W-1:0]      conf_plus1;
    logic                  msg_match;
    logic [PKT_W:0]        tp_low;
    logic [PKT_W-1:0]      tp_sat;
    logic [REC_W:0]        rem_sets;
    logic [SETS_W-1:0]     pkt_count;
    logic [ID_W-1:0]       id_next;
    logic                  out_free;
    logic                  is_end;

    assign out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_eff      = (r_cfg_sensors == '0) ? SENS_W'(1) : r_cfg_sensors;
        spp_eff    = (r_cfg_spp == '0) ? SETS_W'(1) : r_cfg_spp;
        conf_plus1 = r_confirmed + REC_W'(1);
        msg_match  = r_session && r_ok && (r_msg_id == r_current_id);
        id_next    = (r_id_seeded ? r_id_counter : r_cfg_seed) + ID_W'(1);
        is_end     = r_pkt == (r_total_packets - PKT_W'(1));

        tp_low = {1'b0, div_q[PKT_W-1:0]} + (PKT_W+1)'(div_r != '0);
        if (div_q[DIVIDEND_W-1:PKT_W] != '0 || tp_low[PKT_W]) begin
            tp_sat = PKT_TOTAL_MAX;
        end else if (tp_low[PKT_W-1:0] == '0) begin
            tp_sat = PKT_W'(1);
        end else begin
            tp_sat = tp_low[PKT_W-1:0];
        end

        rem_sets = {1'b0, r_total_sets} - {1'b0, mul_p};
        if (rem_sets[REC_W] || rem_sets[REC_W-1:0] == '0) begin
            pkt_count = '0;
        end else if (rem_sets[REC_W-1:0] < {{(REC_W-SETS_W){1'b0}}, r_sets_snap}) begin
            pkt_count = rem_sets[SETS_W-1:0];
        end else begin
            pkt_count = r_sets_snap;
        end
    end

    always_comb begin
        div_start    = (r_state == ST_DIV_SETS) || (r_state == ST_DIV_PKTS);
        div_dividend = (r_state == ST_DIV_SETS) ? (r_next - r_start) : r_total_sets;
        div_divisor  = (r_state == ST_DIV_SETS) ? {{(DIVISOR_W-SENS_W){1'b0}}, n_eff}
                                                : r_sets_snap;
    end

    always_comb begin
        unique case (r_state)
            ST_MUL_OFF: begin
                mul_a = {{(MUL_A_W-PKT_W){1'b0}}, r_pkt};
                mul_b = r_sets_snap;
            end
            ST_MUL_REC: begin
                mul_a = mul_p;
                mul_b = {{(MUL_B_W-SENS_W){1'b0}}, r_sens_snap};
            end
            ST_MUL_CONF: begin
                mul_a = r_total_sets;
                mul_b = {{(MUL_B_W-SENS_W){1'b0}}, r_sens_snap};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sawts_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    sawts_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sensors <= SENS_W'(1);
            r_cfg_spp     <= SETS_W'(1);
            r_cfg_seed    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SENSOR_COUNT:    r_cfg_sensors <= i_cfg_wdata[SENS_W-1:0];
                CFG_SETS_PER_PACKET: r_cfg_spp     <= i_cfg_wdata[SETS_W-1:0];
                CFG_ID_SEED:         r_cfg_seed    <= i_cfg_wdata[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_session       <= 1'b0;
            r_current_id    <= '0;
            r_id_counter    <= '0;
            r_id_seeded     <= 1'b0;
            r_start_record  <= '0;
            r_total_sets    <= '0;
            r_sens_snap     <= SENS_W'(1);
            r_sets_snap     <= SETS_W'(1);
            r_total_packets <= PKT_W'(1);
            r_last_sent     <= '0;
            r_reply         <= 1'b0;
            r_conf          <= 1'b0;
            r_m_valid       <= 1'b0;
        end else begin
            if (r_state == ST_FINISH && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd       <= t_cmd'(s_axis_tuser);
                        r_ok        <= s_axis_tdata[0];
                        r_nonempty  <= s_axis_tdata[1];
                        r_msg_id    <= s_axis_tdata[33:2];
                        r_msg_seq   <= s_axis_tdata[49:34];
                        r_oldest    <= s_axis_tdata[81:50];
                        r_next      <= s_axis_tdata[113:82];
                        r_confirmed <= s_axis_tdata[145:114];
                        r_reply     <= 1'b1;
                        r_conf      <= 1'b0;
                        r_state     <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    unique case (r_cmd)
                        CMD_REQUEST: begin
                            r_start <= (conf_plus1 < r_oldest) ? r_oldest : conf_plus1;
                            r_state <= ST_CLAMP;
                        end
                        CMD_ACK: begin
                            if (!msg_match) begin
                                r_reply <= 1'b0;
                                r_state <= ST_FINISH;
                            end else begin
                                if (r_msg_seq != r_last_sent) begin
                                    r_pkt <= r_last_sent;
                                end else if (r_msg_seq == r_total_packets - PKT_W'(1)) begin
                                    r_pkt  <= r_msg_seq;
                                    r_conf <= r_total_sets != '0;
                                end else begin
                                    r_pkt <= r_msg_seq + PKT_W'(1);
                                end
                                r_state <= ST_MUL_OFF;
                            end
                        end
                        CMD_NACK: begin
                            if (!msg_match || !r_nonempty) begin
                                r_reply <= 1'b0;
                                r_state <= ST_FINISH;
                            end else begin
                                r_pkt   <= r_msg_seq;
                                r_state <= ST_MUL_OFF;
                            end
                        end
                        CMD_BAD: begin
                            r_reply <= 1'b0;
                            r_state <= ST_FINISH;
                        end
                    endcase
                end
                ST_CLAMP: begin
                    if (r_start > r_next) begin
                        r_start <= r_next;
                    end
                    r_state <= ST_DIV_SETS;
                end
                ST_DIV_SETS: begin
                    r_sens_snap <= n_eff;
                    r_sets_snap <= spp_eff;
                    r_state     <= ST_WAIT_SETS;
                end
                ST_WAIT_SETS: begin
                    if (div_done) begin
                        r_total_sets <= div_q;
                        r_state      <= ST_DIV_PKTS;
                    end
                end
                ST_DIV_PKTS: begin
                    r_state <= ST_WAIT_PKTS;
                end
                ST_WAIT_PKTS: begin
                    if (div_done) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    r_total_packets <= tp_sat;
                    r_id_counter    <= id_next;
                    r_id_seeded     <= 1'b1;
                    r_current_id    <= id_next;
                    r_session       <= 1'b1;
                    r_start_record  <= r_start;
                    r_pkt           <= '0;
                    r_state         <= ST_MUL_OFF;
                end
                ST_MUL_OFF: begin
                    r_state <= ST_MUL_REC;
                end
                ST_MUL_REC: begin
                    r_count <= pkt_count;
                    r_state <= ST_MUL_CONF;
                end
                ST_MUL_CONF: begin
                    r_first <= r_start_record + mul_p;
                    r_state <= ST_DESC;
                end
                ST_DESC: begin
                    r_conf_seq <= r_start_record + mul_p - REC_W'(1);
                    r_state    <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        if (r_reply) begin
                            r_last_sent <= r_pkt;
                            r_m_user    <= {r_conf, 1'b1};
                            r_m_last    <= is_end;
                            r_m_data    <= {2'b00,
                                            r_conf ? r_conf_seq : {REC_W{1'b0}},
                                            r_sens_snap, r_first, r_count,
                                            r_total_packets, r_pkt, r_current_id};
                        end else begin
                            r_m_user <= '0;
                            r_m_last <= 1'b0;
                            r_m_data <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

`ifndef SYNTHESIS
    a_one_word_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a word is in flight");

    a_confirm_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && m_axis_tlast))
        else $error("watermark confirmed outside the final packet");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:48] != 16'd0))
        else $error("packet total of zero");

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_WAIT_SETS || r_state == ST_WAIT_PKTS))
        else $error("divider finished outside a wait step");
`endif

endmodule

// ===== dv/tb_stop_and_wait_transfer_sender_core.sv =====
`timescale 1ns / 1ps
module tb_stop_and_wait_transfer_sender_core;
    import sawts_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_WORDS = 210;
    localparam int unsigned SENS_SET [PHASES] = '{0, 32, 63, 1, 5, 33, 17, 1};
    localparam int unsigned SETS_SET [PHASES] = '{0, 255, 1, 255, 3, 0, 40, 1};

    typedef struct {
        t_cmd              cmd;
        logic              ok;
        logic              nonempty;
        logic [ID_W-1:0]   id;
        logic [PKT_W-1:0]  seq;
        logic [REC_W-1:0]  oldest;
        logic [REC_W-1:0]  ring_next;
        logic [REC_W-1:0]  confirmed;
    } t_msg;

    typedef struct {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PKT_W-1:0]  seq;
        logic [PKT_W-1:0]  total;
        logic [SETS_W-1:0] sets;
        logic              last;
        logic [REC_W-1:0]  first_rec;
        logic [SENS_W-1:0] sensors;
        logic              confirm;
        logic [REC_W-1:0]  confirm_seq;
    } t_header;

    class t_header_predictor;
        logic [SENS_W-1:0] cfg_sensors = 1;
        logic [SETS_W-1:0] cfg_sets    = 1;
        logic [ID_W-1:0]   cfg_seed    = 0;
        bit                live        = 0;
        bit                seeded      = 0;
        logic [ID_W-1:0]   xfer_id     = 0;
        logic [ID_W-1:0]   id_count    = 0;
        logic [REC_W-1:0]  base_rec    = 0;
        logic [31:0]       set_total   = 0;
        logic [7:0]        sens_snap   = 1;
        logic [SETS_W-1:0] sets_snap   = 1;
        logic [PKT_W-1:0]  pkt_total   = 1;
        logic [PKT_W-1:0]  sent_seq    = 0;
        t_header           awaited[$];
        int                mismatches  = 0;

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                CFG_SENSOR_COUNT:    cfg_sensors = value[SENS_W-1:0];
                CFG_SETS_PER_PACKET: cfg_sets = value[SETS_W-1:0];
                CFG_ID_SEED:         cfg_seed = value;
                default: ;
            endcase
        endfunction

        function t_header describe(logic [PKT_W-1:0] seq);
            t_header     h;
            logic [31:0] offset;
            logic [31:0] rem;
            offset = 32'(seq) * 32'(sets_snap);
            rem = 0;
            if (set_total > offset) begin
                rem = set_total - offset;
                if (rem > 32'(sets_snap)) rem = 32'(sets_snap);
            end
            h.valid       = 1'b1;
            h.id          = xfer_id;
            h.seq         = seq;
            h.total       = pkt_total;
            h.sets        = rem[SETS_W-1:0];
            h.last        = (seq == pkt_total - 16'd1);
            h.first_rec   = base_rec + offset * 32'(sens_snap);
            h.sensors     = sens_snap[SENS_W-1:0];
            h.confirm     = 1'b0;
            h.confirm_seq = '0;
            sent_seq = seq;
            return h;
        endfunction

        function void note_word(t_msg m);
            t_header     h;
            logic [31:0] start;
            logic [31:0] n;
            logic [31:0] spp;
            logic [31:0] tp;
            h = '{default: '0};
            case (m.cmd)
                CMD_REQUEST: begin
                    start = m.confirmed + 32'd1;
                    if (start < m.oldest) start = m.oldest;
                    if (start > m.ring_next) start = m.ring_next;
                    n = (cfg_sensors == 0) ? 32'd1 : 32'(cfg_sensors);
                    spp = (cfg_sets == 0) ? 32'd1 : 32'(cfg_sets);
                    set_total = (m.ring_next - start) / n;
                    tp = set_total / spp + ((set_total % spp != 0) ? 32'd1 : 32'd0);
                    if (tp > 32'(PKT_TOTAL_MAX)) tp = 32'(PKT_TOTAL_MAX);
                    if (tp == 0) tp = 32'd1;
                    if (!seeded) begin
                        id_count = cfg_seed;
                        seeded = 1;
                    end
                    id_count  = id_count + 32'd1;
                    live      = 1;
                    xfer_id   = id_count;
                    base_rec  = start;
                    sens_snap = n[7:0];
                    sets_snap = spp[SETS_W-1:0];
                    pkt_total = tp[PKT_W-1:0];
                    h = describe(16'd0);
                end
                CMD_ACK: begin
                    if (live && m.ok && m.id == xfer_id) begin
                        if (m.seq != sent_seq) begin
                            h = describe(sent_seq);
                        end else if (m.seq == pkt_total - 16'd1) begin
                            h = describe(m.seq);
                            if (set_total != 0) begin
                                h.confirm     = 1'b1;
                                h.confirm_seq = base_rec + set_total * 32'(sens_snap) - 32'd1;
                            end
                        end else begin
                            h = describe(m.seq + 16'd1);
                        end
                    end
                end
                CMD_NACK: begin
                    if (live && m.ok && m.nonempty && m.id == xfer_id) h = describe(m.seq);
                end
                default: ;
            endcase
            awaited.push_back(h);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_header(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u,
                                   logic last);
            t_header h;
            if (awaited.size() == 0) begin
                $error("packet header: none expected, got %0h", d);
                mismatches++;
                return;
            end
            h = awaited.pop_front();
            check_field("reply_valid", 32'(h.valid), 32'(u[0]));
            check_field("reply_transfer_id", h.id, d[31:0]);
            check_field("packet_seq", 32'(h.seq), 32'(d[47:32]));
            check_field("packet_total", 32'(h.total), 32'(d[63:48]));
            check_field("packet_sets", 32'(h.sets), 32'(d[71:64]));
            check_field("end_flag", 32'(h.last), 32'(last));
            check_field("first_record_seq", h.first_rec, d[103:72]);
            check_field("sensors_per_set", 32'(h.sensors), 32'(d[109:104]));
            check_field("confirm_valid", 32'(h.confirm), 32'(u[1]));
            check_field("confirm_seq", h.confirm_seq, d[141:110]);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    t_header_predictor book = new;
    bit                steady;
    int unsigned       cycles;

    stop_and_wait_transfer_sender_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < 37);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            book.check_header(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_msg make_msg(t_cmd cmd, logic ok, logic nonempty,
                                      logic [ID_W-1:0] id, logic [PKT_W-1:0] seq,
                                      logic [REC_W-1:0] oldest, logic [REC_W-1:0] ring_next,
                                      logic [REC_W-1:0] confirmed);
        t_msg m;
        m.cmd       = cmd;
        m.ok        = ok;
        m.nonempty  = nonempty;
        m.id        = id;
        m.seq       = seq;
        m.oldest    = oldest;
        m.ring_next = ring_next;
        m.confirmed = confirmed;
        return m;
    endfunction

    function automatic t_msg pick_word();
        t_msg        m;
        int unsigned r;
        int unsigned unit;
        logic [31:0] base;
        m = make_msg(CMD_BAD, 1'b1, 1'b1, $urandom, 16'($urandom), $urandom, $urandom,
                     $urandom);
        r = $urandom_range(0, 99);
        if (!book.live || r < 8) begin
            m.cmd = CMD_REQUEST;
            if ($urandom_range(0, 9) != 0) begin
                unit = ((book.cfg_sensors == 0) ? 1 : book.cfg_sensors) *
                       ((book.cfg_sets == 0) ? 1 : book.cfg_sets);
                base = $urandom;
                m.oldest    = base;
                m.confirmed = base + $urandom_range(0, 16) - 9;
                m.ring_next = base + unit * $urandom_range(0, 5) + $urandom_range(0, unit);
            end
        end else if (r < 68) begin
            m.cmd = CMD_ACK;
            m.id  = book.xfer_id;
            m.seq = ($urandom_range(0, 6) == 0) ? 16'($urandom) : book.sent_seq;
        end else if (r < 84) begin
            m.cmd      = CMD_NACK;
            m.id       = book.xfer_id;
            m.ok       = ($urandom_range(0, 9) != 0);
            m.nonempty = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 5) != 0) begin
                m.seq = 16'($urandom_range(0, book.pkt_total - 1));
            end
        end else begin
            m.cmd      = t_cmd'($urandom_range(1, 3));
            m.ok       = 1'($urandom_range(0, 1));
            m.nonempty = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) != 0) m.id = book.xfer_id;
        end
        return m;
    endfunction

    task automatic send_word(t_msg m);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m.cmd;
        s_axis_tdata  <= {6'd0, m.confirmed, m.ring_next, m.oldest, m.seq, m.id,
                          m.nonempty, m.ok};
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_word(m);
        if (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (idle_now());
        end
    endtask

    task automatic request(logic [REC_W-1:0] oldest, logic [REC_W-1:0] ring_next,
                           logic [REC_W-1:0] confirmed);
        send_word(make_msg(CMD_REQUEST, 1'b1, 1'b1, $urandom, 16'($urandom), oldest,
                           ring_next, confirmed));
    endtask

    task automatic reply(t_cmd cmd, logic [PKT_W-1:0] seq);
        send_word(make_msg(cmd, 1'b1, 1'b1, book.xfer_id, seq, $urandom, $urandom, $urandom));
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        book.set_reg(addr, value);
    endtask

    task automatic set_config(logic [31:0] sensors, logic [31:0] sets, logic [31:0] seed);
        write_reg(CFG_SENSOR_COUNT, sensors);
        write_reg(CFG_SETS_PER_PACKET, sets);
        write_reg(CFG_ID_SEED, seed);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_REQUEST;
        m_axis_tready = 1'b0;
        steady        = 1'b0;
        cycles        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(1, 1, 32'hFFFF_FFFF);

        send_word(make_msg(CMD_ACK, 1'b1, 1'b1, '0, '0, '0, '0, '0));
        send_word(make_msg(CMD_NACK, 1'b1, 1'b1, '0, '0, '0, '0, '0));
        send_word(make_msg(CMD_BAD, 1'b1, 1'b1, '0, '0, '0, '0, '0));
        request(32'd10, 32'd15, 32'd3);
        send_word(make_msg(CMD_ACK, 1'b0, 1'b1, book.xfer_id, '0, '0, '0, '0));
        send_word(make_msg(CMD_ACK, 1'b1, 1'b1, book.xfer_id + 32'd1, '0, '0, '0, '0));
        reply(CMD_ACK, 16'd0);
        reply(CMD_ACK, 16'd0);
        send_word(make_msg(CMD_NACK, 1'b1, 1'b0, book.xfer_id, 16'd2, '0, '0, '0));
        send_word(make_msg(CMD_NACK, 1'b0, 1'b1, book.xfer_id, 16'd2, '0, '0, '0));
        reply(CMD_NACK, 16'd3);
        reply(CMD_NACK, 16'hFFFF);
        reply(CMD_NACK, 16'd4);
        reply(CMD_ACK, 16'd4);
        reply(CMD_ACK, 16'd4);
        request(32'd0, 32'd0, 32'hFFFF_FFFF);
        reply(CMD_ACK, 16'd0);
        request(32'd100, 32'd120, 32'd500);
        request(32'hFFFF_FFF0, 32'd5, 32'hFFFF_FFFE);
        request(32'd0, 32'h0010_0000, 32'hFFFF_FFFF);
        reply(CMD_NACK, 16'hFFFE);
        reply(CMD_ACK, 16'hFFFE);
        request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(make_msg(CMD_BAD, 1'b1, 1'b1, '1, '1, '1, '1, '1));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // phase 5 runs with both sides streaming back to back
            steady = (p == 5);
            set_config((p == 6) ? $urandom_range(0, 63) : SENS_SET[p],
                       (p == 6) ? $urandom_range(0, 255) : SETS_SET[p], $urandom);
            repeat (PHASE_WORDS) send_word(pick_word());
            drain();
        end
        steady = 1'b0;

        if (book.mismatches == 0 && book.awaited.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
